@@ rtl/core/bpe_pkg.sv @@
`default_nettype none

package bpe_pkg;

  // Grid size defaults
  localparam int ROWS_DEFAULT = 4;
  localparam int COLS_DEFAULT = 4;

  // Field widths
  localparam int COORD_W = 32;
  localparam int PARAM_W = 17;

  // 1.0 in Q1.16
  localparam logic [PARAM_W-1:0] ONE_Q16 = 17'h10000;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // One point: lane 0 = x, lane 1 = y, lane 2 = z
  typedef logic [2:0][COORD_W-1:0] point_t;

  typedef struct packed {
    logic               command;
    logic [1:0]         row;
    logic [1:0]         column;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [COORD_W-1:0] point_z;
    logic [PARAM_W-1:0] param_u;
    logic [PARAM_W-1:0] param_v;
  } bpe_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] surface_x;
    logic [COORD_W-1:0] surface_y;
    logic [COORD_W-1:0] surface_z;
  } bpe_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_U,
    ST_V,
    ST_DRAIN,
    ST_DONE
  } bpe_state_t;

  // Tag that travels with one lerp through the datapath
  typedef struct packed {
    logic valid;
    logic src_scratch;
    logic use_v;
    logic last;
  } bpe_tag_t;

endpackage

`default_nettype wire

@@ rtl/core/bpe_stream.sv @@
`default_nettype none

interface bpe_stream #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bpe_point_ram.sv @@
`default_nettype none

module bpe_point_ram #(
  parameter int DEPTH = bpe_pkg::ROWS_DEFAULT * bpe_pkg::COLS_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  bpe_pkg::point_t wdata,
  input  logic [AW-1:0]   raddr_a,
  input  logic [AW-1:0]   raddr_b,
  output bpe_pkg::point_t rdata_a,
  output bpe_pkg::point_t rdata_b
);
  import bpe_pkg::*;

  point_t mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ rtl/core/bpe_lerp.sv @@
`default_nettype none

module bpe_lerp (
  input  logic                         clk,
  input  bpe_pkg::point_t              ctl_a,
  input  bpe_pkg::point_t              ctl_b,
  input  bpe_pkg::point_t              scr_a,
  input  bpe_pkg::point_t              scr_b,
  input  logic                         src_scratch,
  input  logic [bpe_pkg::PARAM_W-1:0]  t,
  output bpe_pkg::point_t              result
);
  import bpe_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + PARAM_W + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  point_t                    p1, q1, p2, p3;
  logic [PARAM_W-1:0]        t2;
  logic signed [DIFF_W-1:0]  diff  [3];
  logic signed [DIFF_W-1:0]  diff2 [3];
  logic signed [PROD_W-1:0]  prod  [3];
  logic signed [PROD_W-1:0]  prod3 [3];
  logic signed [PROD_W-1:0]  step  [3];

  // Pick the operand source for this lerp
  always_comb begin
    p1 = src_scratch ? scr_a : ctl_a;
    q1 = src_scratch ? scr_b : ctl_b;
  end

  // Per coordinate: difference, product, rounded floor shift, add back
  for (genvar lane = 0; lane < 3; lane++) begin : g_lane
    assign diff[lane] = $signed({q1[lane][COORD_W-1], q1[lane]})
                      - $signed({p1[lane][COORD_W-1], p1[lane]});
    assign prod[lane] = $signed({1'b0, t2}) * diff2[lane];
    assign step[lane] = (prod3[lane] + ROUND_HALF) >>> 16;
    assign result[lane] = p3[lane] + step[lane][COORD_W-1:0];
  end

  // Stage registers: difference, then product
  always_ff @(posedge clk) begin
    p2    <= p1;
    t2    <= t;
    diff2 <= diff;
    p3    <= p2;
    prod3 <= prod;
  end

endmodule

`default_nettype wire

@@ rtl/core/bpe_seq.sv @@
`default_nettype none

module bpe_seq #(
  parameter int ROWS = bpe_pkg::ROWS_DEFAULT,
  parameter int COLS = bpe_pkg::COLS_DEFAULT,
  parameter int AW   = $clog2(ROWS * COLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_free,
  output logic              idle,
  output logic              finish,
  output logic [AW-1:0]     raddr_a,
  output logic [AW-1:0]     raddr_b,
  output logic              rd_scratch,
  output bpe_pkg::bpe_tag_t tag1,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic              done
);
  import bpe_pkg::*;

  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLS);
  localparam int MAXD = (ROWS > COLS) ? ROWS : COLS;
  localparam int LW   = $clog2(MAXD + 1);

  bpe_state_t      state, state_next;
  logic [RW-1:0]   row;
  logic [CW-1:0]   col;
  logic [LW-1:0]   len;
  bpe_tag_t        tag2, tag3;
  logic [AW-1:0]   dst1, dst2, dst3;

  logic            in_u, in_v, src_scratch;
  logic            col_last, row_last, vrow_last, len_two;
  logic            u_last, v_last, hazard, issue;
  logic [AW-1:0]   addr_a, addr_b;

  function automatic logic pending(input logic [AW-1:0] a,
                                   input bpe_tag_t t1, input logic [AW-1:0] d1,
                                   input bpe_tag_t t2, input logic [AW-1:0] d2,
                                   input bpe_tag_t t3, input logic [AW-1:0] d3);
    pending = (t1.valid && d1 == a) || (t2.valid && d2 == a) || (t3.valid && d3 == a);
  endfunction

  // Level bookkeeping and addresses
  always_comb begin
    in_u        = (state == ST_U);
    in_v        = (state == ST_V);
    src_scratch = !(in_u && 32'(len) == COLS);
    len_two     = (32'(len) == 2);
    col_last    = (32'(col) == 32'(len) - 2);
    row_last    = (32'(row) == ROWS - 1);
    vrow_last   = (32'(row) == 32'(len) - 2);
    u_last      = col_last && row_last && len_two;
    v_last      = vrow_last && len_two;
    addr_a      = AW'(32'(row) * COLS + (in_u ? 32'(col) : 0));
    addr_b      = addr_a + (in_u ? AW'(1) : AW'(COLS));
  end

  // Interlock: hold issue while an operand is still on its way to scratch
  always_comb begin
    hazard = src_scratch &&
             (pending(addr_a, tag1, dst1, tag2, dst2, tag3, dst3) ||
              pending(addr_b, tag1, dst1, tag2, dst2, tag3, dst3));
    issue  = (in_u || in_v) && !hazard;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_U;
      ST_U:     if (issue && u_last) state_next = ST_V;
      ST_V:     if (issue && v_last) state_next = ST_DRAIN;
      ST_DRAIN: if (tag3.valid && tag3.last) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    idle       = (state == ST_IDLE);
    finish     = (state == ST_DONE) && out_free;
    raddr_a    = addr_a;
    raddr_b    = addr_b;
    rd_scratch = issue && src_scratch;
    wr_en      = tag3.valid;
    wr_addr    = dst3;
    done       = tag3.valid && tag3.last;
  end

  // State and level counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      len   <= '0;
    end else begin
      state <= state_next;
      if (start && idle) begin
        row <= '0;
        col <= '0;
        len <= LW'(COLS);
      end else if (issue && in_u) begin
        if (!col_last) begin
          col <= col + CW'(1);
        end else begin
          col <= '0;
          if (!row_last) begin
            row <= row + RW'(1);
          end else begin
            row <= '0;
            len <= len_two ? LW'(ROWS) : len - LW'(1);
          end
        end
      end else if (issue && in_v) begin
        if (!vrow_last) begin
          row <= row + RW'(1);
        end else begin
          row <= '0;
          len <= len - LW'(1);
        end
      end
    end
  end

  // Advance lerp tags along the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else begin
      tag1 <= '{valid: issue, src_scratch: src_scratch, use_v: in_v, last: in_v && v_last};
      tag2 <= tag1;
      tag3 <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    dst1 <= addr_a;
    dst2 <= dst1;
    dst3 <= dst2;
  end

endmodule

`default_nettype wire

@@ rtl/core/bezier_patch_evaluator.sv @@
// Bicubic Bezier patch evaluator, de Casteljau in signed Q16.16.
// Channel cmd takes items: command 0 writes one control point at (row, column)
// into the control memory in the accept cycle; command 1 evaluates the patch at
// (param_u, param_v), values above 1.0 saturate to 1.0. Channel result gives one
// item (surface_x/y/z) per evaluate; loads give none.
// An evaluate runs ROWS*COLS*(COLS-1)/2 lerps in u and ROWS*(ROWS-1)/2 lerps in
// v, all three coordinates side by side, one lerp issued per cycle, barring
// interlock stalls, into a three-stage lerp datapath (difference, multiply, round
// and add) that writes back into a scratch memory. A level stalls while it needs
// a point the previous level is still writing. For the 4x4 grid that is 30 lerps.
// The result becomes valid in the same cycle that cmd opens again. The block
// takes one item at a time.
// Reset (rst, synchronous) returns to idle and empties the result register; the
// control memory is not cleared and must be loaded before use.
// A finished result sits in the output register until taken; cmd stays open
// meanwhile, and a following evaluate holds at its end until the register frees.
`default_nettype none

module bezier_patch_evaluator #(
  parameter int ROWS = bpe_pkg::ROWS_DEFAULT,
  parameter int COLS = bpe_pkg::COLS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  bpe_stream.sink   cmd,
  bpe_stream.source result
);
  import bpe_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  logic               accept, start, ctl_we;
  logic [AW-1:0]      ctl_waddr;
  point_t             ctl_wdata;
  logic [PARAM_W-1:0] u_sat, v_sat, t;
  logic               idle, finish, out_free, rd_scratch, wr_en, done;
  logic [AW-1:0]      raddr_a, raddr_b, wr_addr;
  bpe_tag_t           tag1;
  point_t             ctl_a, ctl_b, scr_a, scr_b, lerp_out, res, out_pt;
  logic               out_valid;

  // Input handshake and load decode
  always_comb begin
    cmd.ready = idle;
    accept    = cmd.valid && cmd.ready;
    start     = accept && (cmd.data.command == CMD_EVAL);
    ctl_we    = accept && (cmd.data.command == CMD_LOAD) &&
                (32'(cmd.data.row) < ROWS) && (32'(cmd.data.column) < COLS);
    ctl_waddr = AW'(32'(cmd.data.row) * COLS + 32'(cmd.data.column));
    ctl_wdata = {cmd.data.point_z, cmd.data.point_y, cmd.data.point_x};
    t         = tag1.use_v ? v_sat : u_sat;
    out_free  = !out_valid || result.ready;
  end

  // Hold saturated parameters for the evaluate in progress
  always_ff @(posedge clk) begin
    if (start) begin
      u_sat <= (cmd.data.param_u > ONE_Q16) ? ONE_Q16 : cmd.data.param_u;
      v_sat <= (cmd.data.param_v > ONE_Q16) ? ONE_Q16 : cmd.data.param_v;
    end
  end

  bpe_point_ram #(.DEPTH(DEPTH), .AW(AW)) u_ctl_ram (
    .clk     (clk),
    .we      (ctl_we),
    .waddr   (ctl_waddr),
    .wdata   (ctl_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (ctl_a),
    .rdata_b (ctl_b)
  );

  bpe_point_ram #(.DEPTH(DEPTH), .AW(AW)) u_scr_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (lerp_out),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (scr_a),
    .rdata_b (scr_b)
  );

  bpe_seq #(.ROWS(ROWS), .COLS(COLS), .AW(AW)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .out_free   (out_free),
    .idle       (idle),
    .finish     (finish),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .rd_scratch (rd_scratch),
    .tag1       (tag1),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .done       (done)
  );

  bpe_lerp u_lerp (
    .clk         (clk),
    .ctl_a       (ctl_a),
    .ctl_b       (ctl_b),
    .scr_a       (scr_a),
    .scr_b       (scr_b),
    .src_scratch (tag1.src_scratch),
    .t           (t),
    .result      (lerp_out)
  );

  // Capture the final lerp
  always_ff @(posedge clk) begin
    if (done) begin
      res <= lerp_out;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_pt <= res;
    end
  end

  always_comb begin
    result.valid          = out_valid;
    result.data.surface_x = out_pt[0];
    result.data.surface_y = out_pt[1];
    result.data.surface_z = out_pt[2];
  end

  // No lerp writes back while the block is open for items
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !wr_en)
    else $error("scratch write while idle");

  // Interlock: never read a scratch entry in the cycle it is written
  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_scratch && wr_en) |-> (raddr_a != wr_addr && raddr_b != wr_addr))
    else $error("scratch read collides with write-back");

  // The final lerp keeps the block busy until the result is handed off
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> !cmd.ready)
    else $error("idle right after final lerp");

  // A hand-off always fills the output register
  a_finish_fill: assert property (@(posedge clk) disable iff (rst)
    finish |=> result.valid)
    else $error("result lost at hand-off");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpe_pkg::*;

  localparam int GRID_ROWS     = ROWS_DEFAULT;
  localparam int GRID_COLS     = COLS_DEFAULT;
  localparam int GRID_SIZE     = GRID_ROWS * GRID_COLS;
  localparam int RANDOM_ITEMS  = 900;
  localparam int IDLE_PCT      = 27;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 60;

  // Holds a copy of the control grid and the patch points it should produce
  class patch_scoreboard;
    int       grid_x[GRID_SIZE];
    int       grid_y[GRID_SIZE];
    int       grid_z[GRID_SIZE];
    bpe_out_t surface_q[$];
    int       errors;
    int       n_loads;
    int       n_evals;
    int       n_checked;

    function new();
      errors    = 0;
      n_loads   = 0;
      n_evals   = 0;
      n_checked = 0;
    endfunction

    // One rounded Q16 interpolation step, product at full width
    function int lerp_q16(int p, int q, int t);
      longint d;
      longint r;
      d = longint'(q) - longint'(p);
      r = longint'(p) + ((longint'(t) * d + 64'sd32768) >>> 16);
      if (r > 64'sd2147483647)
        r = 64'sd2147483647;
      if (r < -64'sd2147483648)
        r = -64'sd2147483648;
      return int'(r);
    endfunction

    // Collapse n points to one by repeated interpolation
    function int collapse(int pts[8], int n, int t);
      for (int len = n; len > 1; len--)
        for (int i = 0; i < len - 1; i++)
          pts[i] = lerp_q16(pts[i], pts[i + 1], t);
      return pts[0];
    endfunction

    function int patch_coord(int grid[GRID_SIZE], int u, int v);
      int row_pts[8];
      int work[8];
      for (int r = 0; r < GRID_ROWS; r++) begin
        for (int c = 0; c < GRID_COLS; c++)
          work[c] = grid[r * GRID_COLS + c];
        row_pts[r] = collapse(work, GRID_COLS, u);
      end
      return collapse(row_pts, GRID_ROWS, v);
    endfunction

    function int pending();
      return surface_q.size();
    endfunction

    // Update the grid on a load, queue the patch point on an evaluate
    function void note_item(bpe_in_t it);
      int       u;
      int       v;
      int       idx;
      bpe_out_t exp_pt;
      if (it.command == CMD_LOAD) begin
        n_loads++;
        if (it.row < GRID_ROWS && it.column < GRID_COLS) begin
          idx = it.row * GRID_COLS + it.column;
          grid_x[idx] = it.point_x;
          grid_y[idx] = it.point_y;
          grid_z[idx] = it.point_z;
        end
      end else begin
        n_evals++;
        u = (it.param_u > ONE_Q16) ? ONE_Q16 : it.param_u;
        v = (it.param_v > ONE_Q16) ? ONE_Q16 : it.param_v;
        exp_pt.surface_x = patch_coord(grid_x, u, v);
        exp_pt.surface_y = patch_coord(grid_y, u, v);
        exp_pt.surface_z = patch_coord(grid_z, u, v);
        surface_q.insert(surface_q.size(), exp_pt);
      end
    endfunction

    function void check_surface(bpe_out_t got);
      bpe_out_t exp_pt;
      if (surface_q.size() == 0) begin
        $error("surface point arrived with none expected");
        errors++;
        return;
      end
      exp_pt = surface_q.pop_front();
      n_checked++;
      if (got.surface_x !== exp_pt.surface_x) begin
        $error("surface_x: expected %0d, got %0d",
               $signed(exp_pt.surface_x), $signed(got.surface_x));
        errors++;
      end
      if (got.surface_y !== exp_pt.surface_y) begin
        $error("surface_y: expected %0d, got %0d",
               $signed(exp_pt.surface_y), $signed(got.surface_y));
        errors++;
      end
      if (got.surface_z !== exp_pt.surface_z) begin
        $error("surface_z: expected %0d, got %0d",
               $signed(exp_pt.surface_z), $signed(got.surface_z));
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic no_idle;
  int   quiet_cycles;

  bpe_stream #(.T(bpe_in_t))  cmd_if ();
  bpe_stream #(.T(bpe_out_t)) res_if ();

  patch_scoreboard sb = new();

  bezier_patch_evaluator i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if),
    .result (res_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Pick a coordinate, leaning toward the extremes now and then
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PARAM_W-1:0] pick_param();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE_Q16;
      2: return PARAM_W'($urandom_range(17'h1FFFF, 17'h10001));
      default: return PARAM_W'($urandom_range(17'h10000));
    endcase
  endfunction

  function automatic bpe_in_t random_item();
    bpe_in_t it;
    it.command = ($urandom_range(99) < 50) ? CMD_LOAD : CMD_EVAL;
    it.row     = 2'($urandom_range(3));
    it.column  = 2'($urandom_range(3));
    it.point_x = pick_coord();
    it.point_y = pick_coord();
    it.point_z = pick_coord();
    it.param_u = pick_param();
    it.param_v = pick_param();
    return it;
  endfunction

  function automatic bpe_in_t eval_item(logic [PARAM_W-1:0] u, logic [PARAM_W-1:0] v);
    bpe_in_t it;
    it         = random_item();
    it.command = CMD_EVAL;
    it.param_u = u;
    it.param_v = v;
    return it;
  endfunction

  // Present one item, idling at random first; call and return at a falling edge
  task automatic send_item(input bpe_in_t it);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  // Stall the result side at random
  always @(negedge clk)
    res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

  // Check every result taken
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_surface(res_if.data);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bpe_in_t it;
    rst          = 1'b1;
    no_idle      = 1'b0;
    quiet_cycles = 0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    res_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the whole grid: x swings between the extremes, y ramps
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        it         = random_item();
        it.command = CMD_LOAD;
        it.row     = 2'(r);
        it.column  = 2'(c);
        it.point_x = ((r + c) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
        it.point_y = (r * GRID_COLS + c) << 16;
        send_item(it);
      end
    end

    // Corners, midpoints and parameters above one
    send_item(eval_item(17'h00000, 17'h00000));
    send_item(eval_item(17'h10000, 17'h10000));
    send_item(eval_item(17'h00000, 17'h10000));
    send_item(eval_item(17'h10000, 17'h00000));
    send_item(eval_item(17'h08000, 17'h08000));
    send_item(eval_item(17'h00001, 17'h0FFFF));
    send_item(eval_item(17'h1FFFF, 17'h1FFFF));
    send_item(eval_item(17'h10001, 17'h0AAAA));

    // Random mix, with one stretch where neither side idles
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle <= (i >= 350 && i < 500);
      send_item(random_item());
    end
    no_idle      <= 1'b0;
    cmd_if.valid <= 1'b0;

    // Drain outstanding results, then allow time for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Loaded %0d control points and evaluated %0d patch points,", sb.n_loads,
             sb.n_evals);
    $display("%0d results compared, including extreme coordinates and saturated u/v",
             sb.n_checked);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
